### rtl/core/hbtt_pkg.sv
// ----------------------------------------------------------------------------
// hbtt_pkg
// shared widths, request and event codes for the heartbeat timeout table
// ----------------------------------------------------------------------------
`default_nettype none

package hbtt_pkg;

    localparam int ID_W   = 6;
    localparam int TMO_W  = 32;
    localparam int CNT_W  = 32;

    // packed stream widths, rounded up to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // request kinds on the slave side
    localparam logic REQ_CHECKIN = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // event kinds on the master side
    localparam logic EVT_REPLY  = 1'b0;
    localparam logic EVT_EXPIRY = 1'b1;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [TMO_W-1:0] t_tmo;
    typedef logic [CNT_W-1:0] t_cnt;

endpackage

`default_nettype wire

### rtl/core/heartbeat_timeout_table_core.sv
// ----------------------------------------------------------------------------
// heartbeat_timeout_table_core
// per-client liveness table with check-in replies and tick-driven expiry
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)                        tuser        tlast
//  s_axis    in   client_id[5:0] timeout_s[37:6]            req_type     -
//  m_axis    out  client_ref[5:0] checkin_count[37:6]       event_kind   last
//                 is_new[38]
//
//  a check-in is accepted, then its entry is read-modify-written and the
//  reply is sent; a zero timeout adds a state for the expiry transfer
//  a tick walks every entry, one per cycle while the walk is not stalled,
//  through the registered read port of the count and remaining-time memories;
//  a stalled master side holds the walk at the next expiry to be reported
//  reset clears the live bits in flip-flops; the memories need no clearing
//  pass since an entry's read data is only used while its live bit is set
// ----------------------------------------------------------------------------
`default_nettype none

module heartbeat_timeout_table_core #(
    parameter int CLIENTS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // client_id[5:0], timeout_s[37:6], zero fill
    input  wire logic [hbtt_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // req_type
    input  wire logic                              i_s_axis_tuser,

    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // client_ref[5:0], checkin_count[37:6], is_new[38], zero fill
    output logic [hbtt_pkg::M_TDATA_W-1:0]         o_m_axis_tdata,
    // event_kind
    output logic                                   o_m_axis_tuser,
    output logic                                   o_m_axis_tlast
);

    // index width into the table
    localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CHK_MOD = 3'd1;
    localparam logic [2:0] ST_CHK_EXP = 3'd2;
    localparam logic [2:0] ST_TK_MOD  = 3'd3;
    localparam logic [2:0] ST_TK_END  = 3'd4;

    // ---------------------------------------------------------------- state
    logic [2:0]          r_state, n_state;
    logic [CLIENTS-1:0]  r_live, n_live;
    hbtt_pkg::t_id       r_id, n_id;
    hbtt_pkg::t_tmo      r_tmo, n_tmo;
    logic                r_oor, n_oor;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_pend_v, n_pend_v;
    logic [IW-1:0]       r_pend_idx, n_pend_idx;

    // output register
    logic                r_m_valid, n_m_valid;
    logic                r_m_kind, n_m_kind;
    hbtt_pkg::t_id       r_m_ref, n_m_ref;
    hbtt_pkg::t_cnt      r_m_cnt, n_m_cnt;
    logic                r_m_new, n_m_new;
    logic                r_m_last, n_m_last;

    // memories: check-in count and remaining seconds, registered read
    hbtt_pkg::t_cnt      mem_hits [CLIENTS];
    hbtt_pkg::t_tmo      mem_rem  [CLIENTS];
    hbtt_pkg::t_cnt      r_rd_hits;
    hbtt_pkg::t_tmo      r_rd_rem;

    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic                hits_we;
    hbtt_pkg::t_cnt      hits_wdata;
    logic                rem_we;
    logic [IW-1:0]       wr_addr;
    hbtt_pkg::t_tmo      rem_wdata;

    // ---------------------------------------------------------------- helpers
    logic                s_acc;
    logic                out_free;
    logic [IW-1:0]       id_idx;
    logic                id_oor;
    logic                cur_live;
    hbtt_pkg::t_cnt      cnt_base;
    hbtt_pkg::t_cnt      cnt_next;
    logic                tk_live;
    logic                tk_expire;
    logic                tk_stall;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    // output register may take a new result this cycle
    assign out_free        = !r_m_valid || i_m_axis_tready;

    assign id_idx   = r_id[IW-1:0];
    assign id_oor   = ({1'b0, i_s_axis_tdata[hbtt_pkg::ID_W-1:0]}
                       >= (hbtt_pkg::ID_W+1)'(CLIENTS));
    assign cur_live = r_live[id_idx];
    assign cnt_base = cur_live ? r_rd_hits : '0;
    assign cnt_next = (cnt_base == hbtt_pkg::CNT_MAX) ? cnt_base
                                                       : cnt_base + 1'b1;

    // tick walk: the entry at r_idx has its remaining time in r_rd_rem
    assign tk_live   = r_live[r_idx];
    assign tk_expire = tk_live && (r_rd_rem <= hbtt_pkg::t_tmo'(1));
    // an earlier expiry must leave before the new one takes its place
    assign tk_stall  = tk_expire && r_pend_v && !out_free;

    always_comb begin
        n_state    = r_state;
        n_live     = r_live;
        n_id       = r_id;
        n_tmo      = r_tmo;
        n_oor      = r_oor;
        n_idx      = r_idx;
        n_pend_v   = r_pend_v;
        n_pend_idx = r_pend_idx;

        n_m_valid  = r_m_valid && !i_m_axis_tready;
        n_m_kind   = r_m_kind;
        n_m_ref    = r_m_ref;
        n_m_cnt    = r_m_cnt;
        n_m_new    = r_m_new;
        n_m_last   = r_m_last;

        rd_en      = 1'b0;
        rd_addr    = '0;
        hits_we    = 1'b0;
        hits_wdata = cnt_next;
        rem_we     = 1'b0;
        wr_addr    = id_idx;
        rem_wdata  = r_tmo;

        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_axis_tuser == hbtt_pkg::REQ_TICK) begin
                        // start the walk at entry zero
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        n_idx    = '0;
                        n_pend_v = 1'b0;
                        n_state  = ST_TK_MOD;
                    end else begin
                        n_id    = i_s_axis_tdata[hbtt_pkg::ID_W-1:0];
                        n_tmo   = i_s_axis_tdata[hbtt_pkg::ID_W +: hbtt_pkg::TMO_W];
                        n_oor   = id_oor;
                        rd_en   = 1'b1;
                        rd_addr = i_s_axis_tdata[IW-1:0];
                        n_state = ST_CHK_MOD;
                    end
                end
            end

            ST_CHK_MOD: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = hbtt_pkg::EVT_REPLY;
                    n_m_ref   = r_id;
                    if (r_oor) begin
                        // unknown client: table untouched, empty reply
                        n_m_cnt  = '0;
                        n_m_new  = 1'b0;
                        n_m_last = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        hits_we          = 1'b1;
                        rem_we           = 1'b1;
                        n_m_cnt          = cnt_next;
                        n_m_new          = !cur_live;
                        n_live[id_idx]   = (r_tmo != '0);
                        if (r_tmo == '0) begin
                            // zero timeout expires the client at once
                            n_m_last = 1'b0;
                            n_state  = ST_CHK_EXP;
                        end else begin
                            n_m_last = 1'b1;
                            n_state  = ST_IDLE;
                        end
                    end
                end
            end

            ST_CHK_EXP: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = hbtt_pkg::EVT_EXPIRY;
                    n_m_ref   = r_id;
                    n_m_cnt   = '0;
                    n_m_new   = 1'b0;
                    n_m_last  = 1'b1;
                    n_state   = ST_IDLE;
                end
            end

            ST_TK_MOD: begin
                if (!tk_stall) begin
                    wr_addr = r_idx;
                    if (tk_expire) begin
                        n_live[r_idx] = 1'b0;
                        if (r_pend_v) begin
                            // a later expiry exists, so this one is not last
                            n_m_valid = 1'b1;
                            n_m_kind  = hbtt_pkg::EVT_EXPIRY;
                            n_m_ref   = hbtt_pkg::ID_W'(r_pend_idx);
                            n_m_cnt   = '0;
                            n_m_new   = 1'b0;
                            n_m_last  = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_idx = r_idx;
                    end else if (tk_live) begin
                        rem_we    = 1'b1;
                        rem_wdata = r_rd_rem - 1'b1;
                    end
                    if (r_idx == IW'(CLIENTS - 1)) begin
                        n_state = ST_TK_END;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx + 1'b1;
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end

            ST_TK_END: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = hbtt_pkg::EVT_EXPIRY;
                    n_m_ref   = hbtt_pkg::ID_W'(r_pend_idx);
                    n_m_cnt   = '0;
                    n_m_new   = 1'b0;
                    n_m_last  = 1'b1;
                    n_pend_v  = 1'b0;
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_live    <= '0;
            r_pend_v  <= 1'b0;
            r_m_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_pend_v  <= n_pend_v;
            r_m_valid <= n_m_valid;
            r_idx     <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_id       <= n_id;
        r_tmo      <= n_tmo;
        r_oor      <= n_oor;
        r_pend_idx <= n_pend_idx;
        r_m_kind   <= n_m_kind;
        r_m_ref    <= n_m_ref;
        r_m_cnt    <= n_m_cnt;
        r_m_new    <= n_m_new;
        r_m_last   <= n_m_last;
    end

    // table memories; an entry is written only after its own read, and the
    // next item is not taken before that write, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (hits_we) begin
            mem_hits[wr_addr] <= hits_wdata;
        end
        if (rem_we) begin
            mem_rem[wr_addr] <= rem_wdata;
        end
        if (rd_en) begin
            r_rd_hits <= mem_hits[rd_addr];
            r_rd_rem  <= mem_rem[rd_addr];
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_kind;
    assign o_m_axis_tlast  = r_m_last;
    assign o_m_axis_tdata  = {1'b0, r_m_new, r_m_cnt, r_m_ref};

    // ---------------------------------------------------------------- checks
    a_expiry_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == hbtt_pkg::EVT_EXPIRY)
            |-> (r_m_cnt == '0 && !r_m_new))
        else $error("expiry transfer carries a count or new flag");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_axis_tuser == hbtt_pkg::REQ_TICK)
            |=> (r_state == ST_TK_MOD && r_idx == '0 && !r_pend_v))
        else $error("tick walk did not start at entry zero");

    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("pending expiry left behind at end of walk");

    a_reply_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == hbtt_pkg::EVT_REPLY && !o_m_axis_tlast)
            |-> (r_state == ST_CHK_EXP))
        else $error("non-final reply without a following expiry");

    a_zero_tmo_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHK_EXP) |-> !r_live[id_idx])
        else $error("zero-timeout client still live");

endmodule

`default_nettype wire

### tb/heartbeat_timeout_table_core_tb.sv
// ----------------------------------------------------------------------------
// heartbeat_timeout_table_core_tb
// self-checking bench for the per-client heartbeat timeout table: a typed
// table of directed requests, then random check-in and tick traffic, with a
// behavioural copy of the liveness table predicting every result transfer
// ----------------------------------------------------------------------------

module heartbeat_timeout_table_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hbtt_pkg::*;

    localparam int NCLIENT    = 64;
    localparam int RAND_ITEMS = 480;

    // one request: req_type, client_id, timeout_s
    typedef struct packed {
        logic req;
        t_id  id;
        t_tmo tmo;
    } hb_req_t;

    // one result: event_kind, client_ref, checkin_count, is_new, last
    typedef struct packed {
        logic kind;
        t_id  client;
        t_cnt count;
        logic fresh;
        logic tail;
    } hb_evt_t;

    // directed row; n_typed < 0 means the predictor supplies the results
    typedef struct {
        hb_req_t rq;
        int      n_typed;
        hb_evt_t ev0;
        hb_evt_t ev1;
    } dir_row_t;

    logic                 i_clk;
    logic                 rst_n   = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data  = '0;
    logic                 s_user  = 1'b0;
    logic                 m_ready = 1'b0;

    wire                  s_ready;
    wire                  m_valid;
    wire [M_TDATA_W-1:0]  m_data;
    wire                  m_user;
    wire                  m_last;

    // liveness table as the bench believes it to be
    logic    live_bits [NCLIENT];
    t_cnt    hit_count [NCLIENT];
    t_tmo    secs_left [NCLIENT];

    hb_evt_t pending_events[$];
    int      n_fail      = 0;
    int      n_req       = 0;
    int      tx_idle_pct = 15;
    int      rx_idle_pct = 87;

    heartbeat_timeout_table_core #(
        .CLIENTS (NCLIENT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // client_id[5:0], timeout_s[37:6], zero fill
        .i_s_axis_tuser  (s_user),   // req_type
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // client_ref[5:0], checkin_count[37:6], is_new[38]
        .o_m_axis_tuser  (m_user),   // event_kind
        .o_m_axis_tlast  (m_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // append one expected result to the outstanding list
    function automatic void add_event(input hb_evt_t ev);
        pending_events.insert(pending_events.size(), ev);
    endfunction

    // apply one accepted request to the table and queue the results it causes
    task automatic predict_events(input hb_req_t rq);
        logic    fresh;
        t_cnt    cnt;
        hb_evt_t held;
        logic    have_held;
        have_held = 1'b0;
        held      = '0;
        if (rq.req == REQ_CHECKIN) begin
            fresh = !live_bits[rq.id];
            cnt   = fresh ? '0 : hit_count[rq.id];
            if (cnt != CNT_MAX)
                cnt = cnt + 1'b1;
            hit_count[rq.id] = cnt;
            secs_left[rq.id] = rq.tmo;
            live_bits[rq.id] = 1'b1;
            // a zero timeout follows the reply with an immediate expiry
            add_event({EVT_REPLY, rq.id, cnt, fresh, rq.tmo != '0});
            if (rq.tmo == '0) begin
                live_bits[rq.id] = 1'b0;
                add_event({EVT_EXPIRY, rq.id, t_cnt'(0), 1'b0, 1'b1});
            end
        end else begin
            // one second passes; expiries go out in ascending index order
            for (int i = 0; i < NCLIENT; i++) begin
                if (live_bits[i]) begin
                    if (secs_left[i] <= 1) begin
                        secs_left[i] = '0;
                        live_bits[i] = 1'b0;
                        if (have_held)
                            add_event(held);
                        held      = {EVT_EXPIRY, t_id'(i), t_cnt'(0), 1'b0, 1'b0};
                        have_held = 1'b1;
                    end else begin
                        secs_left[i] = secs_left[i] - 1'b1;
                    end
                end
            end
            // the final expiry of the tick carries tlast
            if (have_held) begin
                held.tail = 1'b1;
                add_event(held);
            end
        end
    endtask

    // present one request, wait for its transfer, then queue its results
    task automatic put_request(input hb_req_t rq, input int n_typed,
                               input hb_evt_t ev0, input hb_evt_t ev1);
        int n0;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(S_TDATA_W - ID_W - TMO_W){1'b0}}, rq.tmo, rq.id};
        s_user  <= rq.req;
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
        n_req = n_req + 1;
        n0 = pending_events.size();
        predict_events(rq);
        // typed rows replace the predicted results with hand-written ones
        if (n_typed >= 0) begin
            while (pending_events.size() > n0)
                void'(pending_events.pop_back());
            if (n_typed > 0)
                add_event(ev0);
            if (n_typed > 1)
                add_event(ev1);
        end
    endtask

    // check every client in with a short timeout, then tick them all away
    task automatic sweep_table(input int max_tmo);
        for (int i = 0; i < NCLIENT; i++)
            put_request({REQ_CHECKIN, t_id'(i), t_tmo'($urandom_range(1, max_tmo))},
                        -1, '0, '0);
        for (int k = 0; k < max_tmo; k++)
            put_request({REQ_TICK, t_id'(0), t_tmo'(0)}, -1, '0, '0);
    endtask

    // sender goes quiet until every outstanding result has come back
    task automatic drain_results;
        s_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_events.size() != 0);
    endtask

    function automatic dir_row_t row(input hb_req_t rq, input int n_typed,
                                     input hb_evt_t ev0, input hb_evt_t ev1);
        dir_row_t r;
        r.rq      = rq;
        r.n_typed = n_typed;
        r.ev0     = ev0;
        r.ev1     = ev1;
        return r;
    endfunction

    // result monitor: every transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        hb_evt_t got;
        hb_evt_t want;
        if (rst_n && m_valid && m_ready) begin
            got = {m_user, m_data[ID_W-1:0], m_data[ID_W+CNT_W-1:ID_W],
                   m_data[ID_W+CNT_W], m_last};
            if (pending_events.size() == 0) begin
                $error("result transfer with nothing outstanding: kind %0d client_ref %0d",
                       got.kind, got.client);
                n_fail = n_fail + 1;
            end else begin
                want = pending_events.pop_front();
                if (got.kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, got.kind);
                    n_fail = n_fail + 1;
                end
                if (got.client !== want.client) begin
                    $error("client_ref: expected %0d, got %0d", want.client, got.client);
                    n_fail = n_fail + 1;
                end
                if (got.count !== want.count) begin
                    $error("checkin_count: expected %0d, got %0d", want.count, got.count);
                    n_fail = n_fail + 1;
                end
                if (got.fresh !== want.fresh) begin
                    $error("is_new: expected %0d, got %0d", want.fresh, got.fresh);
                    n_fail = n_fail + 1;
                end
                if (got.tail !== want.tail) begin
                    $error("last: expected %0d, got %0d", want.tail, got.tail);
                    n_fail = n_fail + 1;
                end
            end
        end
    end

    initial begin : stimulus
        dir_row_t dir_tab[$];
        int       n_dir;
        int       cur_phase;
        int       phase;
        int       pick;
        t_tmo     tmo;

        for (int i = 0; i < NCLIENT; i++) begin
            live_bits[i] = 1'b0;
            hit_count[i] = '0;
            secs_left[i] = '0;
        end

        // directed rows; typed results are the ones obvious from the rules
        // empty table: a tick gives nothing
        dir_tab = {dir_tab, row({REQ_TICK, 6'd0, 32'd0}, 0, '0, '0)};
        // first check-ins at the lowest and highest index, extreme timeouts
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd0, 32'd1}, 1,
                                {EVT_REPLY, 6'd0, 32'd1, 1'b1, 1'b1}, '0)};
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd63, 32'hFFFF_FFFF}, 1,
                                {EVT_REPLY, 6'd63, 32'd1, 1'b1, 1'b1}, '0)};
        // zero timeout: reply then immediate expiry of the same client
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd5, 32'd0}, 2,
                                {EVT_REPLY, 6'd5, 32'd1, 1'b1, 1'b0},
                                {EVT_EXPIRY, 6'd5, 32'd0, 1'b0, 1'b1})};
        // repeat check-in of a live client
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd0, 32'd2}, 1,
                                {EVT_REPLY, 6'd0, 32'd2, 1'b0, 1'b1}, '0)};
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd42, 32'h5555_5555}, -1, '0, '0)};
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd21, 32'hAAAA_AAAA}, -1, '0, '0)};
        // reload with a shorter timeout
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd42, 32'd1}, -1, '0, '0)};
        dir_tab = {dir_tab, row({REQ_TICK, 6'd0, 32'd0}, -1, '0, '0)};
        dir_tab = {dir_tab, row({REQ_TICK, 6'd0, 32'd0}, -1, '0, '0)};
        // zero timeout on a live client: count carries on, then it goes
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd63, 32'd0}, 2,
                                {EVT_REPLY, 6'd63, 32'd2, 1'b0, 1'b0},
                                {EVT_EXPIRY, 6'd63, 32'd0, 1'b0, 1'b1})};
        // an expired client comes back as new with its count restarted
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd63, 32'd3}, 1,
                                {EVT_REPLY, 6'd63, 32'd1, 1'b1, 1'b1}, '0)};
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd1, 32'd1}, -1, '0, '0)};
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd2, 32'd1}, -1, '0, '0)};
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd3, 32'd2}, -1, '0, '0)};
        // several expiries on one tick, tlast on the highest index only
        dir_tab = {dir_tab, row({REQ_TICK, 6'd0, 32'd0}, -1, '0, '0)};
        dir_tab = {dir_tab, row({REQ_TICK, 6'd0, 32'd0}, -1, '0, '0)};
        // tick with its unused fields all ones
        dir_tab = {dir_tab, row({REQ_TICK, 6'd63, 32'hFFFF_FFFF}, -1, '0, '0)};
        dir_tab = {dir_tab, row({REQ_CHECKIN, 6'd21, 32'd7}, -1, '0, '0)};

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k])
            put_request(dir_tab[k].rq, dir_tab[k].n_typed, dir_tab[k].ev0, dir_tab[k].ev1);
        n_dir = n_req;

        // sender holds off until the directed results are all back
        drain_results();

        // one full-table tick up front so the widest expiry burst is seen
        sweep_table(1);

        cur_phase = 0;
        while (n_req < n_dir + RAND_ITEMS) begin
            phase = (n_req - n_dir) * 3 / RAND_ITEMS;
            if (phase > 2)
                phase = 2;
            if (phase != cur_phase) begin
                drain_results();
                cur_phase = phase;
                case (phase)
                    1: begin
                        tx_idle_pct = 87;
                        rx_idle_pct = 15;
                    end
                    default: begin
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end
                endcase
            end

            pick = $urandom_range(199);
            if (pick < 2) begin
                sweep_table(3);
            end else if (pick < 45) begin
                put_request({REQ_TICK, t_id'($urandom), t_tmo'($urandom)}, -1, '0, '0);
            end else begin
                // mostly short timeouts so clients expire within a few ticks
                pick = $urandom_range(99);
                if (pick < 8)
                    tmo = '0;
                else if (pick < 60)
                    tmo = $urandom_range(1, 4);
                else if (pick < 85)
                    tmo = $urandom_range(5, 30);
                else
                    tmo = $urandom;
                put_request({REQ_CHECKIN, t_id'($urandom_range(NCLIENT - 1)), tmo},
                            -1, '0, '0);
            end
        end

        drain_results();
        // a tick scans the whole table, so allow a full walk for strays
        repeat (NCLIENT + 16) @(posedge i_clk);

        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### heartbeat_timeout_table_core.f
rtl/core/hbtt_pkg.sv
rtl/core/heartbeat_timeout_table_core.sv
tb/heartbeat_timeout_table_core_tb.sv
